// ===== rtl/core/bfrw_pkg.sv =====
// Shared types, codes and constants for the byte FIFO with rewind window.
`timescale 1ns / 1ps

package bfrw_pkg;

	// Default ring size in bytes
	localparam int CAPACITY_DEF = 4096;

	// Window register and item field widths
	localparam int PEEK_W     = 12;
	localparam int OFFSET_W   = 48;
	localparam int BYTE_W     = 8;
	localparam int PEEK_RESET = 1024;

	// Configuration port
	localparam int APB_DW = 32;
	localparam int ADDR_W = 2;
	localparam logic [ADDR_W-1:0] REG_PEEK_ADDR = 2'd0;

	// Largest distance back from the read point that a history read can ask for
	localparam int MAX_BACK = (2 ** PEEK_W) - 1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_ABORT = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_DONE    = 4'd0,
		ST_HIST    = 4'd1,
		ST_FWD     = 4'd2,
		ST_FULL    = 4'd3,
		ST_EMPTY   = 4'd4,
		ST_EOS     = 4'd5,
		ST_ABORTED = 4'd6,
		ST_TOO_OLD = 4'd7,
		ST_REFUSED = 4'd8
	} status_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [BYTE_W-1:0]   data_byte;
		logic [OFFSET_W-1:0] offset;
		logic                last_byte;
	} cmd_item_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] read_byte;
		logic              last_byte_res;
	} res_item_t;

	// First subtrahend of the ring-modulo reduction: the largest cap << k that
	// does not exceed MAX_BACK, or zero when no reduction is ever needed.
	function automatic int red_init(input int cap);
		int s;
		s = 0;
		if (cap <= MAX_BACK) begin
			s = cap;
			for (int k = 0; k < PEEK_W; k++) begin
				if (s * 2 <= MAX_BACK) begin
					s = s * 2;
				end
			end
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/bfrw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfrw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/byte_fifo_with_rewind_window_top.sv =====
// Top level of the byte FIFO with rewind window: control sequencer, state and ring RAM.
`timescale 1ns / 1ps

//  channel | direction | payload      | handshake
//  --------+-----------+--------------+-----------------------------------------
//  cmd     | in        | cmd_item_t   | transfer when cmd_valid && !cmd_stall
//  res     | out       | res_item_t   | transfer when res_valid && !res_stall
//  apb     | in/out    | window reg   | write when psel && penable && pwrite
//
//  One command is in flight at a time; the ring RAM has registered read data.
//  Write, close, abort and every refused command: evaluate, then output.
//  Forward read: evaluate, load, output. History read: evaluate, the steps of the
//  ring-modulo reduction (none when CAPACITY >= 4096), history, load, output.
//  Reset needs no clearing pass; the ring holds no valid bits.
//  A stalled result holds in the output register while the sequencer waits.

module byte_fifo_with_rewind_window_top #(
	parameter int CAPACITY = bfrw_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  bfrw_pkg::cmd_item_t             cmd_item,
	output logic                            res_valid,
	input  logic                            res_stall,
	output bfrw_pkg::res_item_t             res_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bfrw_pkg::ADDR_W-1:0]     paddr,
	input  logic [bfrw_pkg::APB_DW-1:0]     pwdata,
	output logic [bfrw_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = bfrw_pkg::PEEK_W;
	localparam int OW = bfrw_pkg::OFFSET_W;
	localparam int BW = bfrw_pkg::BYTE_W;
	localparam int AW = ((IW > PW) ? IW : PW) + 1;
	localparam int SW = ((CW > PW) ? CW : PW) + 1;
	localparam int RED_INIT = bfrw_pkg::red_init(CAPACITY);
	localparam bit NEED_RED = (RED_INIT != 0);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EVAL = 6'b000010,
		S_MOD  = 6'b000100,
		S_HIST = 6'b001000,
		S_LOAD = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_d, ev_next;

	// Stream state
	logic [IW-1:0]    wr_idx_q, rd_idx_q;
	logic [CW-1:0]    unread_q, held_q;
	logic [OW-1:0]    consumed_q;
	logic             closed_q, aborted_q;
	logic [PW-1:0]    peek_q;

	// Item and result holding
	bfrw_pkg::cmd_item_t item_q;
	bfrw_pkg::status_t   status_q, ev_status;
	logic [BW-1:0]       byte_q;
	logic [PW-1:0]       rem_q, sub_q;
	logic                res_valid_q;
	bfrw_pkg::res_item_t res_q;

	// Evaluation results
	logic ev_wr, ev_fwd, ev_close, ev_abort;
	logic too_old, is_hist, mod_done, out_free, cfg_wr;
	logic [PW-1:0] back_dist;
	logic [CW-1:0] unread_dec, held_fwd;
	logic [SW-1:0] keep_lim;
	logic [AW-1:0] pos_full;
	logic [IW-1:0] hist_pos, wr_idx_nxt, rd_idx_nxt;

	// RAM port signals
	logic          ram_we;
	logic [IW-1:0] ram_raddr;
	logic [BW-1:0] ram_rdata;

	// Handshake outputs
	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res_item  = res_q;
	assign out_free  = !res_valid_q || !res_stall;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == bfrw_pkg::REG_PEEK_ADDR);
	assign prdata = (paddr == bfrw_pkg::REG_PEEK_ADDR) ?
		{{(bfrw_pkg::APB_DW - PW){1'b0}}, peek_q} : '0;

	// Window and history tests: offset + window < consumed means too old
	assign too_old   = ({1'b0, item_q.offset} + (OW + 1)'(peek_q)) < {1'b0, consumed_q};
	assign is_hist   = item_q.offset < consumed_q;
	// A history distance never exceeds the window, so the low bits suffice
	assign back_dist = consumed_q[PW-1:0] - item_q.offset[PW-1:0];

	// Ring index advance
	assign wr_idx_nxt = (wr_idx_q == IW'(CAPACITY - 1)) ? '0 : wr_idx_q + 1'b1;
	assign rd_idx_nxt = (rd_idx_q == IW'(CAPACITY - 1)) ? '0 : rd_idx_q + 1'b1;

	// Forward read trims kept history to the window
	assign unread_dec = unread_q - 1'b1;
	assign keep_lim   = SW'(unread_dec) + SW'(peek_q);
	assign held_fwd   = (SW'(held_q) > keep_lim) ? keep_lim[CW-1:0] : held_q;

	// History position: read index minus reduced distance, around the ring
	assign pos_full = AW'(rd_idx_q)
		+ ((AW'(rd_idx_q) < AW'(rem_q)) ? AW'(CAPACITY) : '0)
		- AW'(rem_q);
	assign hist_pos = pos_full[IW-1:0];

	assign mod_done = (sub_q == PW'(CAPACITY));

	// Command decode in the evaluate cycle
	always_comb begin
		ev_status = bfrw_pkg::ST_DONE;
		ev_next   = S_OUT;
		ev_wr     = 1'b0;
		ev_fwd    = 1'b0;
		ev_close  = 1'b0;
		ev_abort  = 1'b0;
		unique case (item_q.cmd)
			bfrw_pkg::CMD_WRITE: begin
				if (aborted_q || closed_q) begin
					ev_status = bfrw_pkg::ST_REFUSED;
				end else if (held_q == CW'(CAPACITY)) begin
					ev_status = bfrw_pkg::ST_FULL;
				end else begin
					ev_wr = 1'b1;
				end
			end
			bfrw_pkg::CMD_READ: begin
				if (too_old) begin
					ev_status = bfrw_pkg::ST_TOO_OLD;
				end else if (is_hist) begin
					ev_status = bfrw_pkg::ST_HIST;
					ev_next   = NEED_RED ? S_MOD : S_HIST;
				end else if (aborted_q) begin
					ev_status = bfrw_pkg::ST_ABORTED;
				end else if (unread_q == '0) begin
					ev_status = closed_q ? bfrw_pkg::ST_EOS : bfrw_pkg::ST_EMPTY;
				end else begin
					ev_status = bfrw_pkg::ST_FWD;
					ev_fwd    = 1'b1;
					ev_next   = S_LOAD;
				end
			end
			bfrw_pkg::CMD_CLOSE: begin
				ev_close = 1'b1;
			end
			bfrw_pkg::CMD_ABORT: begin
				ev_abort = 1'b1;
			end
		endcase
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: state_d = ev_next;
			S_MOD: begin
				if (mod_done) begin
					state_d = S_HIST;
				end
			end
			S_HIST: state_d = S_LOAD;
			S_LOAD: state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM access: writes and forward reads in evaluate, history reads later
	assign ram_we    = (state_q == S_EVAL) && ev_wr;
	assign ram_raddr = (state_q == S_HIST) ? hist_pos : rd_idx_q;

	bfrw_ram #(
		.WIDTH(BW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx_q),
		.wdata(item_q.data_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			unread_q    <= '0;
			held_q      <= '0;
			consumed_q  <= '0;
			closed_q    <= 1'b0;
			aborted_q   <= 1'b0;
			peek_q      <= PW'(bfrw_pkg::PEEK_RESET);
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				peek_q <= pwdata[PW-1:0];
			end
			if (state_q == S_EVAL) begin
				if (ev_wr) begin
					wr_idx_q <= wr_idx_nxt;
					unread_q <= unread_q + 1'b1;
					held_q   <= held_q + 1'b1;
				end
				if (ev_fwd) begin
					rd_idx_q <= rd_idx_nxt;
					unread_q <= unread_dec;
					held_q   <= held_fwd;
					if (consumed_q != '1) begin
						consumed_q <= consumed_q + 1'b1;
					end
				end
				if (ev_close) begin
					closed_q <= 1'b1;
				end
				if (ev_abort) begin
					aborted_q <= 1'b1;
				end
			end
			// Output register valid
			if ((state_q == S_OUT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_q <= cmd_item;
		end
		if (state_q == S_EVAL) begin
			status_q <= ev_status;
			byte_q   <= '0;
			rem_q    <= back_dist;
			sub_q    <= PW'(RED_INIT);
		end
		// One restoring step of distance modulo ring size
		if (state_q == S_MOD) begin
			if (rem_q >= sub_q) begin
				rem_q <= rem_q - sub_q;
			end
			sub_q <= sub_q >> 1;
		end
		if (state_q == S_LOAD) begin
			byte_q <= ram_rdata;
		end
		if ((state_q == S_OUT) && out_free) begin
			res_q.status        <= status_q;
			res_q.read_byte     <= byte_q;
			res_q.last_byte_res <= item_q.last_byte;
		end
	end

endmodule

// ===== rtl/core/bfrw_checker.sv =====
// Port-level checker for the byte FIFO with rewind window, bound to the top level.
`timescale 1ns / 1ps

module bfrw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_stall,
	input bfrw_pkg::cmd_item_t         cmd_item,
	input logic                        res_valid,
	input logic                        res_stall,
	input bfrw_pkg::res_item_t         res_item,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [bfrw_pkg::ADDR_W-1:0] paddr,
	input logic [bfrw_pkg::APB_DW-1:0] pwdata,
	input logic [bfrw_pkg::APB_DW-1:0] prdata,
	input logic                        pready
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result changed");

	// Only data-bearing statuses carry a nonzero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.status == bfrw_pkg::ST_HIST ||
			res_item.status == bfrw_pkg::ST_FWD || res_item.read_byte == '0))
		else $error("nonzero byte with a non-data status");

	// The block works on one command at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second command taken while one is in flight");

	// Window register reads back what was written
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr == bfrw_pkg::REG_PEEK_ADDR
		|=> paddr != bfrw_pkg::REG_PEEK_ADDR ||
			prdata[bfrw_pkg::PEEK_W-1:0] == $past(pwdata[bfrw_pkg::PEEK_W-1:0]))
		else $error("window register readback mismatch");

endmodule

bind byte_fifo_with_rewind_window_top bfrw_checker u_bfrw_checker (.*);

// ===== verif/bfrw_reply_checker.sv =====
// Reply checker for the byte FIFO with rewind window: tracks the ring and checks every reply.
`timescale 1ns / 1ps

module bfrw_reply_checker import bfrw_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic                cmd_stall,
	input  cmd_item_t           cmd_item,
	input  logic                res_valid,
	input  logic                res_stall,
	input  res_item_t           res_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output int                  fail_count,
	output int                  outstanding,
	output logic [OFFSET_W-1:0] stream_pos
);

	// Shadow of the ring and its bookkeeping
	logic [BYTE_W-1:0]   ring_bytes [CAPACITY];
	int                  wr_ptr;
	int                  rd_ptr;
	int                  unread;
	int                  held;
	logic [OFFSET_W-1:0] consumed;
	bit                  closed;
	bit                  aborted;
	int                  window_len;

	res_item_t pending_replies [$];
	res_item_t want;

	// Reply that one command gets, updating the shadow state on the way
	function automatic res_item_t fifo_reply(input cmd_item_t it);
		res_item_t           r;
		logic [OFFSET_W-1:0] earliest;
		int                  back;
		int                  pos;
		int                  lag;
		r.status        = ST_DONE;
		r.read_byte     = '0;
		r.last_byte_res = it.last_byte;
		case (it.cmd)
			CMD_WRITE: begin
				// refusal takes precedence over full
				if (aborted || closed) begin
					r.status = ST_REFUSED;
				end else if (held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					ring_bytes[wr_ptr] = it.data_byte;
					wr_ptr = (wr_ptr + 1) % CAPACITY;
					unread++;
					held++;
				end
			end
			CMD_READ: begin
				earliest = (consumed > OFFSET_W'(window_len)) ?
					consumed - OFFSET_W'(window_len) : '0;
				if (it.offset < earliest) begin
					r.status = ST_TOO_OLD;
				end else if (it.offset < consumed) begin
					// history byte, counted back from the read point
					back = int'(consumed - it.offset) % CAPACITY;
					pos = (rd_ptr + CAPACITY - back) % CAPACITY;
					r.read_byte = ring_bytes[pos];
					r.status = ST_HIST;
				end else if (aborted) begin
					r.status = ST_ABORTED;
				end else if (unread == 0) begin
					r.status = closed ? ST_EOS : ST_EMPTY;
				end else begin
					r.read_byte = ring_bytes[rd_ptr];
					rd_ptr = (rd_ptr + 1) % CAPACITY;
					unread--;
					if (consumed != {OFFSET_W{1'b1}}) begin
						consumed++;
					end
					// trim kept history down to the window
					lag = held - unread;
					if (lag > window_len) begin
						held -= lag - window_len;
					end
					r.status = ST_FWD;
				end
			end
			CMD_CLOSE: closed = 1'b1;
			default:   aborted = 1'b1;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr     = 0;
			rd_ptr     = 0;
			unread     = 0;
			held       = 0;
			consumed   = '0;
			closed     = 1'b0;
			aborted    = 1'b0;
			window_len = PEEK_RESET;
			fail_count = 0;
			pending_replies.delete();
			outstanding <= 0;
			stream_pos  <= '0;
		end else begin
			// window register write
			if (psel && penable && pwrite && pready && paddr == REG_PEEK_ADDR) begin
				window_len = int'(pwdata[PEEK_W-1:0]);
			end

			// command transfer: queue its reply
			if (cmd_valid && !cmd_stall) begin
				pending_replies.push_back(fifo_reply(cmd_item));
			end

			// reply transfer: compare against the oldest queued reply
			if (res_valid && !res_stall) begin
				if (pending_replies.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected reply: expected none, got status %0d byte %02h last %0b",
						$time, res_item.status, res_item.read_byte, res_item.last_byte_res);
				end else begin
					want = pending_replies.pop_front();
					if (res_item.status !== want.status ||
						res_item.read_byte !== want.read_byte ||
						res_item.last_byte_res !== want.last_byte_res) begin
						fail_count++;
						$display("%0t: reply mismatch: expected status %0d byte %02h last %0b, got status %0d byte %02h last %0b",
							$time, want.status, want.read_byte, want.last_byte_res,
							res_item.status, res_item.read_byte, res_item.last_byte_res);
					end
				end
			end

			outstanding <= pending_replies.size();
			stream_pos  <= consumed;
		end
	end

endmodule

// ===== verif/byte_fifo_with_rewind_window_top_tb.sv =====
// Testbench top for the byte FIFO with rewind window: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module byte_fifo_with_rewind_window_top_tb;
	import bfrw_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 252;

	logic                clk;
	logic                arst_n;
	logic                cmd_valid;
	logic                cmd_stall;
	cmd_item_t           cmd_item;
	logic                res_valid;
	logic                res_stall;
	res_item_t           res_item;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	int                  fail_count;
	int                  outstanding;
	logic [OFFSET_W-1:0] stream_pos;

	bit idle_on   = 1'b1;
	bit long_hold = 1'b0;
	int cur_window = PEEK_RESET;

	byte_fifo_with_rewind_window_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	bfrw_reply_checker reply_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd_item    (cmd_item),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_item    (res_item),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.stream_pos  (stream_pos)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic cmd_item_t make_item(input cmd_t op, input logic [BYTE_W-1:0] b,
			input logic [OFFSET_W-1:0] off, input logic l);
		cmd_item_t it;
		it.cmd       = op;
		it.data_byte = b;
		it.offset    = off;
		it.last_byte = l;
		return it;
	endfunction

	// Read aimed at the next unread byte
	function automatic cmd_item_t read_next();
		return make_item(CMD_READ, BYTE_W'($urandom),
			stream_pos + OFFSET_W'($urandom_range(0, 3)), 1'($urandom));
	endfunction

	// Random command, offsets aimed around the window edges
	function automatic cmd_item_t random_item(input int write_pct);
		cmd_item_t           it;
		logic [OFFSET_W-1:0] pos;
		int                  span;
		int                  old_lim;
		pos     = stream_pos;
		old_lim = int'(pos) - cur_window;
		span    = (int'(pos) < cur_window) ? int'(pos) : cur_window;
		it      = make_item(CMD_READ, BYTE_W'($urandom), {16'($urandom), $urandom},
			1'($urandom));
		if ($urandom_range(0, 99) < write_pct) begin
			it.cmd = CMD_WRITE;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: it.offset = pos + OFFSET_W'($urandom_range(0, 2));
				3, 4, 5: if (span > 0) it.offset = pos - OFFSET_W'($urandom_range(1, span));
				6:       if (old_lim > 0) it.offset = OFFSET_W'(old_lim - 1);
				7:       if (old_lim >= 0) it.offset = OFFSET_W'(old_lim);
				8:       if (old_lim > 0) it.offset = OFFSET_W'($urandom_range(0, old_lim - 1));
				default: ;
			endcase
		end
		return it;
	endfunction

	// One command transfer, with an occasional gap in front
	task automatic send_cmd(input cmd_item_t it);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= it;
		do @(posedge clk); while (cmd_stall);
	endtask

	// Wait for every reply, then let the sequencer drain
	task automatic settle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_window(input int w);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_PEEK_ADDR;
		pwdata  <= APB_DW'(w);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_window = w;
	endtask

	// Reply side: short random stalls, plus one long hold-off on request
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				res_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			quiet = ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) ? 0 : quiet + 1;
		end
		$display("byte_fifo_with_rewind_window_top_tb: errors");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd_item  <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ring, then a few bytes through forward and history reads
		send_cmd(make_item(CMD_READ, 8'h00, 48'd0, 1'b1));
		send_cmd(make_item(CMD_WRITE, 8'h00, 48'd0, 1'b0));
		send_cmd(make_item(CMD_WRITE, 8'hFF, {OFFSET_W{1'b1}}, 1'b1));
		send_cmd(make_item(CMD_WRITE, 8'h5A, 48'd0, 1'b0));
		send_cmd(make_item(CMD_READ, 8'hFF, 48'd0, 1'b0));
		send_cmd(make_item(CMD_READ, 8'h00, {OFFSET_W{1'b1}}, 1'b1));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd0, 1'b0));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd1, 1'b1));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd2, 1'b0));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd2, 1'b0));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd3, 1'b1));

		// no history kept at all
		set_window(0);
		send_cmd(make_item(CMD_WRITE, 8'h3C, 48'd0, 1'b0));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd0, 1'b1));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd3, 1'b0));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd3, 1'b0));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd4, 1'b1));

		// single byte of history
		set_window(1);
		send_cmd(make_item(CMD_WRITE, 8'hC3, 48'd0, 1'b1));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd4, 1'b0));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd4, 1'b1));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd3, 1'b0));

		// random traffic over several window sizes
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       set_window(16);
				1:       set_window(0);
				2:       set_window(1);
				4:       set_window((1 << PEEK_W) - 1);
				5:       set_window($urandom_range(0, 63));
				default: set_window($urandom_range(0, (1 << PEEK_W) - 1));
			endcase
			idle_on = (ph % 3) != 2;
			if (ph == 1) begin
				long_hold = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_cmd(random_item((ph % 2) ? 30 : 55));
			end
		end

		// closing sequence, no idling: writes, close, refusals, end of stream, abort
		settle();
		idle_on = 1'b0;
		send_cmd(make_item(CMD_WRITE, 8'h81, 48'd0, 1'b0));
		send_cmd(make_item(CMD_WRITE, 8'h7E, 48'd0, 1'b1));
		send_cmd(make_item(CMD_CLOSE, 8'h00, 48'd0, 1'b0));
		send_cmd(make_item(CMD_WRITE, 8'hE7, 48'd0, 1'b1));
		send_cmd(make_item(CMD_CLOSE, 8'hFF, {OFFSET_W{1'b1}}, 1'b1));
		send_cmd(read_next());
		send_cmd(read_next());
		send_cmd(make_item(CMD_READ, 8'h00, {OFFSET_W{1'b1}}, 1'b0));
		send_cmd(make_item(CMD_READ, 8'h00, stream_pos - 48'd1, 1'b1));
		send_cmd(make_item(CMD_READ, 8'h00, stream_pos - 48'd4000, 1'b0));
		send_cmd(make_item(CMD_ABORT, 8'h00, 48'd0, 1'b1));
		send_cmd(make_item(CMD_ABORT, 8'hFF, {OFFSET_W{1'b1}}, 1'b0));
		send_cmd(read_next());
		send_cmd(make_item(CMD_WRITE, 8'h18, 48'd0, 1'b1));
		send_cmd(make_item(CMD_READ, 8'h00, stream_pos - 48'd2, 1'b0));
		send_cmd(make_item(CMD_READ, 8'h00, 48'd0, 1'b1));

		settle();
		if (fail_count == 0 && outstanding == 0) begin
			$display("byte_fifo_with_rewind_window_top_tb: clean");
		end else begin
			$display("byte_fifo_with_rewind_window_top_tb: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/bfrw_pkg.sv
rtl/core/bfrw_ram.sv
rtl/core/byte_fifo_with_rewind_window_top.sv
rtl/core/bfrw_checker.sv
verif/bfrw_reply_checker.sv
verif/byte_fifo_with_rewind_window_top_tb.sv
